// ===== rtl/core/gbfp_pkg.sv =====
`default_nettype none

package gbfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hBE;
    localparam logic [7:0] SYNC_SECOND = 8'hEF;

    localparam logic [7:0] TYPE_BASE_A = 8'h22;
    localparam logic [7:0] TYPE_SOL_0  = 8'h50;
    localparam logic [7:0] TYPE_SOL_1  = 8'h51;
    localparam logic [7:0] TYPE_SOL_2  = 8'h52;
    localparam logic [7:0] TYPE_SOL_3  = 8'h53;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2
    } t_event_kind;

    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_length;
        logic        known_type;
        logic [31:0] good_count;
        logic [31:0] error_count;
    } t_result;

    // CRC-16, MSB first, no reflection, one byte per call
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic type_known(input logic [7:0] t);
        return (t == TYPE_BASE_A) || (t == TYPE_SOL_0) || (t == TYPE_SOL_1) ||
               (t == TYPE_SOL_2) || (t == TYPE_SOL_3);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gnss_binary_frame_parser_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                    Payload
// rx byte   in         i_in_valid / o_in_ready      i_rx_byte
// result    out        o_out_valid / i_out_ready    o_event_kind .. o_error_count
//
// One byte per cycle sustained while the output queue has space. A byte is taken
// into the input register, then parsing (state update and bytewise CRC) pushes at
// most one result into a two-deep output queue, from whose register it is shown.
// Synchronous active-low reset returns the parser to hunting and clears counters.
// Output stalls back up only once the queue holds two results; a byte that
// makes no result still waits for that space.
module gnss_binary_frame_parser_core #(
    parameter int COUNTER_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_frame_length,
    output logic        o_known_type,
    output logic [31:0] o_good_count,
    output logic [31:0] o_error_count
);

    gbfp_pkg::t_result push_res;
    gbfp_pkg::t_result head_res;
    logic              push;
    logic              full;

    // parsing stage: input register, phase machine, CRC and frame counters
    gbfp_parser #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_res_full (full),
        .o_res_push (push),
        .o_res      (push_res)
    );

    // result skid: keeps bytes flowing while a result waits to be taken
    gbfp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (push_res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (head_res)
    );

    assign o_event_kind   = 2'(head_res.event_kind);
    assign o_data_byte    = head_res.data_byte;
    assign o_byte_index   = head_res.byte_index;
    assign o_frame_type   = head_res.frame_type;
    assign o_frame_length = head_res.frame_length;
    assign o_known_type   = head_res.known_type;
    assign o_good_count   = head_res.good_count;
    assign o_error_count  = head_res.error_count;

endmodule

`default_nettype wire

// ===== rtl/core/gbfp_parser.sv =====
`default_nettype none

module gbfp_parser #(
    parameter int COUNTER_BITS = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [7:0]       i_rx_byte,
    input  wire              i_res_full,
    output logic             o_res_push,
    output gbfp_pkg::t_result o_res
);

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_SYNC1   = 7'b0000010,
        PH_SYNC2   = 7'b0000100,
        PH_TYPE    = 7'b0001000,
        PH_PAYLOAD = 7'b0010000,
        PH_CRC_LO  = 7'b0100000,
        PH_CRC_HI  = 7'b1000000
    } t_phase;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        advance;

    // parser state
    t_phase            r_phase,  n_phase;
    logic [7:0]        r_type,   n_type;
    logic [7:0]        r_length, n_length;
    logic [7:0]        r_taken,  n_taken;
    logic [15:0]       r_crc,    n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic [COUNTER_BITS-1:0] r_good,  n_good;
    logic [COUNTER_BITS-1:0] r_error, n_error;

    logic [15:0]       crc_next;
    logic [7:0]        taken_inc;
    logic              emit;
    gbfp_pkg::t_event_kind kind;
    logic [7:0]        data_b;
    logic [7:0]        index_b;
    logic              known;
    logic [COUNTER_BITS+31:0] good_ext;
    logic [COUNTER_BITS+31:0] error_ext;

    assign advance = r_in_valid && !i_res_full;
    assign o_ready = !r_in_valid || !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign crc_next  = gbfp_pkg::crc_add(r_crc, r_in_byte);
    assign taken_inc = r_taken + 8'd1;

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_length = r_length;
        n_taken  = r_taken;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_good   = r_good;
        n_error  = r_error;
        emit     = 1'b0;
        kind     = gbfp_pkg::EV_BAD;
        data_b   = 8'd0;
        index_b  = 8'd0;
        known    = 1'b0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (r_in_byte == gbfp_pkg::SYNC_SECOND) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                end
            end
            PH_SYNC2: begin
                n_type = r_in_byte;
                if (r_in_byte == 8'd0) begin
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                end else begin
                    n_crc   = crc_next;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_length = r_in_byte;
                if (r_in_byte == 8'd0) begin
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                end else begin
                    n_crc   = crc_next;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = crc_next;
                n_taken = taken_inc;
                if (taken_inc >= r_length) begin
                    n_phase = PH_CRC_LO;
                end
                emit    = 1'b1;
                kind    = gbfp_pkg::EV_DATA;
                data_b  = r_in_byte;
                index_b = r_taken;
            end
            PH_CRC_LO: begin
                n_crc_lo = r_in_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_phase = PH_HUNT;
                emit    = 1'b1;
                if ({r_in_byte, r_crc_lo} == r_crc) begin
                    kind = gbfp_pkg::EV_GOOD;
                    if (gbfp_pkg::type_known(r_type)) begin
                        known  = 1'b1;
                        n_good = r_good + COUNTER_BITS'(1);
                    end else begin
                        n_error = r_error + COUNTER_BITS'(1);
                    end
                end
            end
            default: begin
                // hunting, and any code that is not a live phase
                n_phase = PH_HUNT;
                if (r_in_byte == gbfp_pkg::SYNC_FIRST) begin
                    n_phase  = PH_SYNC1;
                    n_type   = 8'd0;
                    n_length = 8'd0;
                    n_taken  = 8'd0;
                    n_crc    = 16'd0;
                    n_crc_lo = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_type   <= 8'd0;
            r_length <= 8'd0;
            r_taken  <= 8'd0;
            r_crc    <= 16'd0;
            r_crc_lo <= 8'd0;
            r_good   <= '0;
            r_error  <= '0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_length <= n_length;
            r_taken  <= n_taken;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_good   <= n_good;
            r_error  <= n_error;
        end
    end

    // counters report their low 32 bits, zero-extended when narrower
    assign good_ext  = (COUNTER_BITS + 32)'(n_good);
    assign error_ext = (COUNTER_BITS + 32)'(n_error);

    assign o_res_push = advance && emit;

    always_comb begin
        o_res.event_kind   = kind;
        o_res.data_byte    = data_b;
        o_res.byte_index   = index_b;
        o_res.frame_type   = n_type;
        o_res.frame_length = n_length;
        o_res.known_type   = known;
        o_res.good_count   = good_ext[31:0];
        o_res.error_count  = error_ext[31:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/gbfp_out_queue.sv =====
`default_nettype none

module gbfp_out_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  gbfp_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  wire               i_ready,
    output gbfp_pkg::t_result o_res
);

    gbfp_pkg::t_result r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int ITEMS        = 1800;
    localparam int CALM_ITEMS   = 200;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 500000;

    typedef enum logic [2:0] {
        P_HUNT, P_SYNC1, P_SYNC2, P_TYPE, P_PAYLOAD, P_CRC_LO, P_CRC_HI
    } t_parse_phase;

    // where a directed byte comes from: typed in, or the running CRC of the frame
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC_LO, SRC_CRC_HI} t_src;

    typedef struct packed {
        t_src                  src;
        logic [7:0]            lit;
        logic                  typed;
        logic                  has_res;
        gbfp_pkg::t_event_kind kind;
        logic [7:0]            ftype;
        logic [7:0]            flen;
    } t_row;

    localparam int N_DIRECTED = 27;

    // Typed rows all come before the first good frame, so both counts are zero there.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{SRC_LIT,    8'h00, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},  // hunting, ignored
        '{SRC_LIT,    8'hFF, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hBE, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h00, 1'b1, 1'b1, gbfp_pkg::EV_BAD,  8'h00, 8'h00},  // bad second sync
        '{SRC_LIT,    8'hBE, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hBE, 1'b1, 1'b1, gbfp_pkg::EV_BAD,  8'h00, 8'h00},  // consumed
        '{SRC_LIT,    8'hBE, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hEF, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h00, 1'b1, 1'b1, gbfp_pkg::EV_BAD,  8'h00, 8'h00},  // zero type
        '{SRC_LIT,    8'hBE, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hEF, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hFF, 1'b1, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h00, 1'b1, 1'b1, gbfp_pkg::EV_BAD,  8'hFF, 8'h00},  // zero length
        '{SRC_LIT,    8'hBE, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},  // known, good
        '{SRC_LIT,    8'hEF, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h53, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hFF, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hBE, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},  // unknown, good
        '{SRC_LIT,    8'hEF, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'hFF, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h01, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_LIT,    8'h00, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_CRC_LO, 8'h00, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00},
        '{SRC_CRC_HI, 8'h00, 1'b0, 1'b0, gbfp_pkg::EV_DATA, 8'h00, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        rx_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        res_ready = 1'b1;
    logic        rx_ready;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_data;
    logic [7:0]  res_index;
    logic [7:0]  res_type;
    logic [7:0]  res_length;
    logic        res_known;
    logic [31:0] res_good;
    logic [31:0] res_error;

    gnss_binary_frame_parser_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (rx_valid),
        .o_in_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .o_event_kind   (res_kind),
        .o_data_byte    (res_data),
        .o_byte_index   (res_index),
        .o_frame_type   (res_type),
        .o_frame_length (res_length),
        .o_known_type   (res_known),
        .o_good_count   (res_good),
        .o_error_count  (res_error)
    );

    // parser shadow state
    t_parse_phase ph       = P_HUNT;
    logic [7:0]   cur_type = 8'h00;
    logic [7:0]   cur_len  = 8'h00;
    logic [7:0]   taken    = 8'h00;
    logic [15:0]  pred_crc = 16'h0000;
    logic [7:0]   crc_lo   = 8'h00;
    logic [31:0]  good_cnt = 32'd0;
    logic [31:0]  err_cnt  = 32'd0;

    gbfp_pkg::t_result pending_results [$];

    int  n_items     = 0;
    int  n_errors    = 0;
    int  n_data      = 0;
    int  n_good      = 0;
    int  n_bad       = 0;
    int  cycle_count = 0;
    bit  calm        = 1'b0;
    bit  hold_req    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // CRC-16/XMODEM, one input bit at a time
    function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ 16'h1021;
            end
        end
        return c;
    endfunction

    function automatic logic is_known_type(input logic [7:0] t);
        return t == gbfp_pkg::TYPE_BASE_A || t == gbfp_pkg::TYPE_SOL_0 ||
               t == gbfp_pkg::TYPE_SOL_1 || t == gbfp_pkg::TYPE_SOL_2 ||
               t == gbfp_pkg::TYPE_SOL_3;
    endfunction

    // advance the shadow parser by one byte; fire says whether a result is due
    task automatic track_frame(input logic [7:0] b, output bit fire,
                               output gbfp_pkg::t_result r);
        fire = 1'b0;
        r    = '0;
        case (ph)
            P_SYNC1: begin
                if (b == gbfp_pkg::SYNC_SECOND) begin
                    ph = P_SYNC2;
                end else begin
                    ph = P_HUNT;
                    fire = 1'b1;
                    r.event_kind = gbfp_pkg::EV_BAD;
                end
            end
            P_SYNC2: begin
                cur_type = b;
                if (b == 8'h00) begin
                    ph = P_HUNT;
                    fire = 1'b1;
                    r.event_kind = gbfp_pkg::EV_BAD;
                end else begin
                    pred_crc = crc_xmodem_byte(pred_crc, b);
                    ph = P_TYPE;
                end
            end
            P_TYPE: begin
                cur_len = b;
                if (b == 8'h00) begin
                    ph = P_HUNT;
                    fire = 1'b1;
                    r.event_kind = gbfp_pkg::EV_BAD;
                end else begin
                    pred_crc = crc_xmodem_byte(pred_crc, b);
                    ph = P_PAYLOAD;
                end
            end
            P_PAYLOAD: begin
                fire = 1'b1;
                r.event_kind = gbfp_pkg::EV_DATA;
                r.data_byte  = b;
                r.byte_index = taken;
                pred_crc = crc_xmodem_byte(pred_crc, b);
                taken = taken + 8'd1;
                if (taken >= cur_len) begin
                    ph = P_CRC_LO;
                end
            end
            P_CRC_LO: begin
                crc_lo = b;
                ph = P_CRC_HI;
            end
            P_CRC_HI: begin
                ph = P_HUNT;
                fire = 1'b1;
                if ({b, crc_lo} != pred_crc) begin
                    r.event_kind = gbfp_pkg::EV_BAD;
                end else if (is_known_type(cur_type)) begin
                    good_cnt = good_cnt + 32'd1;
                    r.event_kind = gbfp_pkg::EV_GOOD;
                    r.known_type = 1'b1;
                end else begin
                    err_cnt = err_cnt + 32'd1;
                    r.event_kind = gbfp_pkg::EV_GOOD;
                end
            end
            default: begin
                ph = P_HUNT;
                if (b == gbfp_pkg::SYNC_FIRST) begin
                    ph       = P_SYNC1;
                    cur_type = 8'h00;
                    cur_len  = 8'h00;
                    taken    = 8'h00;
                    pred_crc = 16'h0000;
                    crc_lo   = 8'h00;
                end
            end
        endcase
        if (fire) begin
            r.frame_type   = cur_type;
            r.frame_length = cur_len;
            r.good_count   = good_cnt;
            r.error_count  = err_cnt;
        end
    endtask

    // Offer one byte, wait for the transaction, queue what it should produce.
    // Entered and left at a falling edge; valid is left high for a follow-on byte.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_fire = 1'b0,
                             input gbfp_pkg::t_result typed_res = '0);
        int                gap;
        bit                fire;
        bit                counted;
        gbfp_pkg::t_result r;
        gap = 0;
        if (!calm && !hold_req && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        counted = !(ph == P_HUNT && b != gbfp_pkg::SYNC_FIRST);
        do @(posedge i_clk); while (!rx_ready);
        track_frame(b, fire, r);
        if (typed) begin
            fire = typed_fire;
            r    = typed_res;
        end
        if (fire) begin
            pending_results.push_back(r);
        end
        if (counted) begin
            n_items++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] t, input logic [7:0] l, input int n_pay,
                              input bit with_crc, input bit corrupt);
        logic [15:0] c;
        send_byte(gbfp_pkg::SYNC_FIRST);
        send_byte(gbfp_pkg::SYNC_SECOND);
        send_byte(t);
        send_byte(l);
        repeat (n_pay) send_byte(8'($urandom_range(0, 255)));
        if (with_crc) begin
            c = pred_crc;
            if (corrupt) begin
                c = c ^ (16'h0001 << $urandom_range(0, 15));
            end
            send_byte(c[7:0]);
            send_byte(c[15:8]);
        end
    endtask

    function automatic logic [7:0] pick_type();
        logic [7:0] known [5];
        known = '{gbfp_pkg::TYPE_BASE_A, gbfp_pkg::TYPE_SOL_0, gbfp_pkg::TYPE_SOL_1,
                  gbfp_pkg::TYPE_SOL_2, gbfp_pkg::TYPE_SOL_3};
        if ($urandom_range(0, 9) < 4) begin
            return known[$urandom_range(0, 4)];
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // mostly short payloads, the odd long one
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            return 8'($urandom_range(1, 8));
        end else if (r < 98) begin
            return 8'($urandom_range(9, 40));
        end
        return 8'($urandom_range(200, 255));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_side
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                res_ready <= 1'b1;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                res_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
                res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        gbfp_pkg::t_result want;
        if (i_rst_n && res_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d data %0h",
                         $time, res_kind, res_data);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("event_kind",   32'(want.event_kind),   32'(res_kind));
                check_field("data_byte",    32'(want.data_byte),    32'(res_data));
                check_field("byte_index",   32'(want.byte_index),   32'(res_index));
                check_field("frame_type",   32'(want.frame_type),   32'(res_type));
                check_field("frame_length", 32'(want.frame_length), 32'(res_length));
                check_field("known_type",   32'(want.known_type),   32'(res_known));
                check_field("good_count",   want.good_count,        res_good);
                check_field("error_count",  want.error_count,       res_error);
                case (want.event_kind)
                    gbfp_pkg::EV_DATA: n_data++;
                    gbfp_pkg::EV_GOOD: n_good++;
                    default:           n_bad++;
                endcase
            end
        end
    end

    initial begin : stimulus
        t_row              row;
        gbfp_pkg::t_result want;
        logic [7:0]        b;
        logic [7:0]        t;
        logic [7:0]        l;
        int                pick;
        int                n;
        bit                hold_done;
        bit                pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            case (row.src)
                SRC_CRC_LO: b = pred_crc[7:0];
                SRC_CRC_HI: b = pred_crc[15:8];
                default:    b = row.lit;
            endcase
            want = '0;
            want.event_kind   = row.kind;
            want.frame_type   = row.ftype;
            want.frame_length = row.flen;
            send_byte(b, row.typed, row.has_res, want);
        end

        // longest frame, unknown extreme type
        send_frame(8'hFF, 8'hFF, 255, 1'b1, 1'b0);

        while (n_items < ITEMS) begin
            if (n_items > ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (!hold_done && n_items > 700) begin
                // sink stalls while a steady frame keeps coming, so the input backs up
                hold_req = 1'b1;
                send_frame(gbfp_pkg::TYPE_SOL_1, 8'd40, 40, 1'b1, 1'b0);
                rx_valid <= 1'b0;
                do @(negedge i_clk); while (hold_req);
                hold_done = 1'b1;
            end
            if (!pause_done && n_items > 1200) begin
                rx_valid <= 1'b0;
                do @(negedge i_clk); while (pending_results.size() != 0);
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                l = pick_len();
                send_frame(pick_type(), l, int'(l), 1'b1, $urandom_range(0, 9) == 0);
            end else if (pick < 80) begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                b = 8'($urandom_range(0, 255));
                if (b == gbfp_pkg::SYNC_SECOND) begin
                    b = gbfp_pkg::SYNC_FIRST;
                end
                send_byte(gbfp_pkg::SYNC_FIRST);
                send_byte(b);
            end else if (pick < 90) begin
                send_byte(gbfp_pkg::SYNC_FIRST);
                send_byte(gbfp_pkg::SYNC_SECOND);
                send_byte(8'h00);
            end else if (pick < 95) begin
                send_byte(gbfp_pkg::SYNC_FIRST);
                send_byte(gbfp_pkg::SYNC_SECOND);
                send_byte(pick_type());
                send_byte(8'h00);
            end else begin
                // cut short: later bytes land in this payload
                t = pick_type();
                l = 8'($urandom_range(2, 8));
                send_frame(t, l, $urandom_range(1, int'(l) - 1), 1'b0, 1'b0);
            end
        end

        rx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d frame bytes sent, %0d payload bytes checked", n_items, n_data);
        $display("summary: %0d good and %0d bad frame ends, long sink hold-off included",
                 n_good, n_bad);
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
